// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL; all checks run on clk and pause in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== src/tkrt_pkg.sv =====
`timescale 1ns / 1ps

package tkrt_pkg;

	localparam int SCORE_W     = 20;
	localparam int LINES_W     = 10;
	localparam int RANK_W      = 3;
	localparam int SDIG_W      = 3;
	localparam int LDIG_W      = 2;
	localparam int KIND_W      = 2;
	localparam int ENTRIES_DEF = 7;

	localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(999999);
	localparam logic [LINES_W-1:0] LINES_MAX = LINES_W'(999);

	// s_tdata: score, lines; m_tdata: rank, score, lines, score digits, line digits
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [LINES_W-1:0] lines;
	} rec_t;

	typedef struct packed {
		logic capture;  // latch the accepted item
		logic apply;    // update the table, rewind the rank index
		logic push;     // load the next beat into the output register
	} cmd_t;

	typedef struct packed {
		logic out_free; // output register empty or being drained
		logic at_last;  // rank index points at the final entry
	} status_t;

	// a must stand behind b
	function automatic logic ranks_below(rec_t a, rec_t b);
		return (a.score < b.score) || ((a.score == b.score) && (a.lines > b.lines));
	endfunction

	function automatic logic [SDIG_W-1:0] score_digits(logic [SCORE_W-1:0] v);
		logic [SDIG_W-1:0] n;
		if (v >= SCORE_W'(100000))     n = SDIG_W'(6);
		else if (v >= SCORE_W'(10000)) n = SDIG_W'(5);
		else if (v >= SCORE_W'(1000))  n = SDIG_W'(4);
		else if (v >= SCORE_W'(100))   n = SDIG_W'(3);
		else if (v >= SCORE_W'(10))    n = SDIG_W'(2);
		else                           n = SDIG_W'(1);
		return n;
	endfunction

	function automatic logic [LDIG_W-1:0] lines_digits(logic [LINES_W-1:0] v);
		logic [LDIG_W-1:0] n;
		if (v >= LINES_W'(100))     n = LDIG_W'(3);
		else if (v >= LINES_W'(10)) n = LDIG_W'(2);
		else                        n = LDIG_W'(1);
		return n;
	endfunction

endpackage

// ===== src/top_k_ranked_table_top.sv =====
`timescale 1ns / 1ps
// Ranked table of ENTRIES (score, lines) records, best score first, fewer
// lines first on equal scores, older records ahead of equal newer ones.
// s_tuser carries the kind: insert (overwrites the last rank, then moves the
// record up to its place), clear, or read; any other kind acts as a read.
// Every item answers with a run of ENTRIES beats, rank 0 first, m_tlast on
// the final rank. An item is taken, the table updates in the next cycle,
// then one beat per cycle is loaded into the output register while that
// register is free; the next item is taken only once the last beat is
// loaded. The single output register sends one record per beat.

module top_k_ranked_table_top #(
	parameter int ENTRIES = tkrt_pkg::ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tkrt_pkg::S_TDATA_W-1:0]   s_tdata,  // score[19:0], lines[29:20]
	input  logic [tkrt_pkg::KIND_W-1:0]      s_tuser,  // kind[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tkrt_pkg::M_TDATA_W-1:0]   m_tdata,  // rank[2:0], entry_score[22:3],
	                                                   // entry_lines[32:23],
	                                                   // score_digits[35:33],
	                                                   // lines_digits[37:36]
	output logic                             m_tlast
);
	import tkrt_pkg::*;

	cmd_t               cmd;
	status_t            st;
	logic [RANK_W-1:0]  rank;
	logic [SCORE_W-1:0] entry_score;
	logic [LINES_W-1:0] entry_lines;
	logic [SDIG_W-1:0]  sdig;
	logic [LDIG_W-1:0]  ldig;

	tkrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	tkrt_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_kind   (s_tuser),
		.in_score  (s_tdata[SCORE_W-1:0]),
		.in_lines  (s_tdata[SCORE_W+LINES_W-1:SCORE_W]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rank  (rank),
		.out_score (entry_score),
		.out_lines (entry_lines),
		.out_sdig  (sdig),
		.out_ldig  (ldig),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, ldig, sdig, entry_lines, entry_score, rank};

endmodule

// ===== src/tkrt_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tkrt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output tkrt_pkg::cmd_t    cmd,
	input  tkrt_pkg::status_t st
);
	import tkrt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_UPD  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.apply   = (state_q == ST_UPD);
	assign cmd.push    = (state_q == ST_EMIT) && st.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_UPD;
			end
			ST_UPD:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (cmd.push && st.at_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	`ASSERT_NEXT(a_capture_then_update, cmd.capture, state_q == ST_UPD)
	`ASSERT_IMPL(a_push_only_when_free, cmd.push, st.out_free)

endmodule

// ===== src/tkrt_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tkrt_dp #(
	parameter int ENTRIES = tkrt_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tkrt_pkg::cmd_t                cmd,
	output tkrt_pkg::status_t             st,
	input  logic [tkrt_pkg::KIND_W-1:0]   in_kind,
	input  logic [tkrt_pkg::SCORE_W-1:0]  in_score,
	input  logic [tkrt_pkg::LINES_W-1:0]  in_lines,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tkrt_pkg::RANK_W-1:0]   out_rank,
	output logic [tkrt_pkg::SCORE_W-1:0]  out_score,
	output logic [tkrt_pkg::LINES_W-1:0]  out_lines,
	output logic [tkrt_pkg::SDIG_W-1:0]   out_sdig,
	output logic [tkrt_pkg::LDIG_W-1:0]   out_ldig,
	output logic                          out_last
);
	import tkrt_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	kind_t              kind_q;
	rec_t               new_q;
	rec_t               tbl_q [ENTRIES];
	rec_t               ins   [ENTRIES];
	logic [ENTRIES-1:0] worse;
	logic [IDX_W-1:0]   idx_q;
	rec_t               sel;
	logic               valid_q;

	// Saturate on capture so the table never holds out-of-range values.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q       <= kind_t'(in_kind);
			new_q.score  <= (in_score > SCORE_MAX) ? SCORE_MAX : in_score;
			new_q.lines  <= (in_lines > LINES_MAX) ? LINES_MAX : in_lines;
		end
	end

	// The table is always sorted, so entries worse than the new record form a
	// tail; the last entry is dropped regardless.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (i == ENTRIES - 1) worse[i] = 1'b1;
			else                  worse[i] = ranks_below(tbl_q[i], new_q);
		end
		ins[0] = worse[0] ? new_q : tbl_q[0];
		for (int i = 1; i < ENTRIES; i++) begin
			if (!worse[i])         ins[i] = tbl_q[i];
			else if (worse[i - 1]) ins[i] = tbl_q[i - 1];
			else                   ins[i] = new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) tbl_q[i] <= '0;
		end else if (cmd.apply) begin
			case (kind_q)
				KIND_INSERT: begin
					for (int i = 0; i < ENTRIES; i++) tbl_q[i] <= ins[i];
				end
				KIND_CLEAR: begin
					for (int i = 0; i < ENTRIES; i++) tbl_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        idx_q <= '0;
		else if (cmd.apply) idx_q <= '0;
		else if (cmd.push)  idx_q <= idx_q + IDX_W'(1);
	end

	assign sel         = tbl_q[idx_q];
	assign st.at_last  = (idx_q == IDX_W'(ENTRIES - 1));
	assign st.out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        valid_q <= 1'b0;
		else if (cmd.push)  valid_q <= 1'b1;
		else if (out_ready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_rank  <= RANK_W'(idx_q);
			out_score <= sel.score;
			out_lines <= sel.lines;
			out_sdig  <= score_digits(sel.score);
			out_ldig  <= lines_digits(sel.lines);
			out_last  <= st.at_last;
		end
	end

	assign out_valid = valid_q;

	`ASSERT_NEXT(a_apply_rewinds, cmd.apply, idx_q == '0)
	`ASSERT_IMPL(a_head_sorted, 1'b1, !ranks_below(tbl_q[0], tbl_q[1]))

endmodule

// ===== test/top_k_ranked_table_top_tb.sv =====
`timescale 1ns / 1ps

module top_k_ranked_table_top_tb;

	import tkrt_pkg::*;

	localparam int NUM_RANKS = ENTRIES_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [RANK_W-1:0]  rank;
		logic [SCORE_W-1:0] score;
		logic [LINES_W-1:0] lines;
		logic [SDIG_W-1:0]  sdig;
		logic [LDIG_W-1:0]  ldig;
		logic               is_last;
	} rank_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0]    s_tuser = KIND_READ;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	rec_t       ranked_table [NUM_RANKS];
	rank_beat_t pending_beats [$];
	logic       quiet = 1'b0;
	int         errors = 0;
	int         stall_cycles = 0;
	int         items_sent = 0;
	int         inserts_sent = 0;
	int         clears_sent = 0;
	int         beats_checked = 0;

	top_k_ranked_table_top #(.ENTRIES(NUM_RANKS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic int decimal_width(int unsigned v);
		int n;
		n = 1;
		while (v >= 10) begin
			v = v / 10;
			n++;
		end
		return n;
	endfunction

	// Apply one item to the table copy, then queue the full run it produces.
	task automatic predict_table_run(logic [KIND_W-1:0] kind, logic [SCORE_W-1:0] score,
			logic [LINES_W-1:0] lines);
		rec_t       fresh;
		rank_beat_t beat;
		int         pos;
		case (kind)
			KIND_INSERT: begin
				fresh.score = (score > SCORE_MAX) ? SCORE_MAX : score;
				fresh.lines = (lines > LINES_MAX) ? LINES_MAX : lines;
				// overwrite the bottom rank, then shift weaker records down
				pos = NUM_RANKS - 1;
				while (pos > 0 && ((ranked_table[pos-1].score < fresh.score) ||
						(ranked_table[pos-1].score == fresh.score &&
						ranked_table[pos-1].lines > fresh.lines))) begin
					ranked_table[pos] = ranked_table[pos-1];
					pos--;
				end
				ranked_table[pos] = fresh;
			end
			KIND_CLEAR: begin
				for (int i = 0; i < NUM_RANKS; i++) ranked_table[i] = '0;
			end
			default: ;
		endcase
		for (int i = 0; i < NUM_RANKS; i++) begin
			beat.rank    = RANK_W'(i);
			beat.score   = ranked_table[i].score;
			beat.lines   = ranked_table[i].lines;
			beat.sdig    = SDIG_W'(decimal_width(ranked_table[i].score));
			beat.ldig    = LDIG_W'(decimal_width(ranked_table[i].lines));
			beat.is_last = (i == NUM_RANKS - 1);
			pending_beats.push_back(beat);
		end
	endtask

	// Valid stays high between back-to-back items; it drops only for a gap.
	task automatic send_item(logic [KIND_W-1:0] kind, logic [SCORE_W-1:0] score,
			logic [LINES_W-1:0] lines);
		if (!quiet && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_TDATA_W - SCORE_W - LINES_W){1'b0}}, lines, score};
		do @(posedge clk); while (!s_tready);
		predict_table_run(kind, score, lines);
		items_sent++;
		if (kind == KIND_INSERT) inserts_sent++;
		if (kind == KIND_CLEAR) clears_sent++;
	endtask

	always @(posedge clk) begin
		m_tready <= arst_n && (quiet || $urandom_range(99) >= 30);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
	end

	always @(posedge clk) begin
		rank_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				beats_checked++;
				if (m_tdata[2:0] !== want.rank) begin
					$error("rank: expected %0d, got %0d", want.rank, m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[22:3] !== want.score) begin
					$error("entry_score: expected %0d, got %0d", want.score, m_tdata[22:3]);
					errors++;
				end
				if (m_tdata[32:23] !== want.lines) begin
					$error("entry_lines: expected %0d, got %0d", want.lines, m_tdata[32:23]);
					errors++;
				end
				if (m_tdata[35:33] !== want.sdig) begin
					$error("score_digits: expected %0d, got %0d", want.sdig, m_tdata[35:33]);
					errors++;
				end
				if (m_tdata[37:36] !== want.ldig) begin
					$error("lines_digits: expected %0d, got %0d", want.ldig, m_tdata[37:36]);
					errors++;
				end
				if (m_tlast !== want.is_last) begin
					$error("last: expected %0b, got %0b", want.is_last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	task automatic test_reset_read();
		send_item(KIND_READ, '0, '0);
	endtask

	task automatic test_field_extremes();
		send_item(KIND_INSERT, 20'd999999, 10'd999);
		send_item(KIND_INSERT, 20'd0, 10'd0);
		send_item(KIND_INSERT, 20'hFFFFF, 10'h3FF);
		send_item(KIND_INSERT, 20'd1000000, 10'd5);
		send_item(KIND_INSERT, 20'd5, 10'd1000);
	endtask

	task automatic test_tie_order();
		send_item(KIND_INSERT, 20'd500, 10'd10);
		send_item(KIND_INSERT, 20'd500, 10'd9);
		send_item(KIND_INSERT, 20'd500, 10'd10);
		send_item(KIND_INSERT, 20'd500, 10'd100);
		send_item(KIND_INSERT, 20'd999999, 10'd0);
	endtask

	task automatic test_kind_handling();
		send_item(KIND_READ, 20'hFFFFF, 10'h3FF);
		send_item(KIND_UNUSED, 20'h5A5A5, 10'h2A5);
		send_item(KIND_CLEAR, 20'hFFFFF, 10'h3FF);
		send_item(KIND_UNUSED, 20'h0, 10'h0);
	endtask

	task automatic test_digit_bounds();
		send_item(KIND_INSERT, 20'd9, 10'd9);
		send_item(KIND_INSERT, 20'd10, 10'd10);
		send_item(KIND_INSERT, 20'd99, 10'd99);
		send_item(KIND_INSERT, 20'd100, 10'd100);
		send_item(KIND_INSERT, 20'd9999, 10'd999);
		send_item(KIND_INSERT, 20'd10000, 10'd1);
		send_item(KIND_INSERT, 20'd99999, 10'd50);
		send_item(KIND_INSERT, 20'd100000, 10'd500);
	endtask

	function automatic logic [SCORE_W-1:0] pick_score();
		logic [SCORE_W-1:0] edges [14] = '{0, 9, 10, 99, 100, 999, 1000, 9999, 10000,
			99999, 100000, 999999, 1000000, 20'hFFFFF};
		int roll;
		roll = $urandom_range(99);
		if (roll < 40) return SCORE_W'($urandom_range(20));
		if (roll < 60) return edges[$urandom_range(13)];
		if (roll < 85) return SCORE_W'($urandom());
		return SCORE_W'($urandom_range(999999));
	endfunction

	function automatic logic [LINES_W-1:0] pick_lines();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40) return LINES_W'($urandom_range(5));
		if (roll < 65) return LINES_W'($urandom());
		return LINES_W'($urandom_range(999));
	endfunction

	task automatic test_random_mix(int count);
		int roll;
		for (int n = 0; n < count; n++) begin
			// hold both sides busy through a middle stretch
			quiet <= (n >= count / 3) && (n < count / 2);
			roll = $urandom_range(99);
			if (roll < 74) send_item(KIND_INSERT, pick_score(), pick_lines());
			else if (roll < 78) send_item(KIND_CLEAR, SCORE_W'($urandom()), LINES_W'($urandom()));
			else if (roll < 90) send_item(KIND_READ, SCORE_W'($urandom()), LINES_W'($urandom()));
			else send_item(KIND_UNUSED, SCORE_W'($urandom()), LINES_W'($urandom()));
		end
		quiet <= 1'b0;
	endtask

	initial begin
		for (int i = 0; i < NUM_RANKS; i++) ranked_table[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_read();
		test_field_extremes();
		test_tie_order();
		test_kind_handling();
		test_digit_bounds();
		test_random_mix(250);

		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (2 * NUM_RANKS + 10) @(posedge clk);
		if (pending_beats.size() != 0) begin
			$error("%0d expected beats never arrived", pending_beats.size());
			errors++;
		end

		$display("Covered %0d items (%0d inserts, %0d clears, rest reads) and %0d ranked beats.",
			items_sent, inserts_sent, clears_sent, beats_checked);
		$display("Saturation, tie order, digit widths and unused kind included; %0d errors.",
			errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/tkrt_pkg.sv
src/tkrt_ctrl.sv
src/tkrt_dp.sv
src/top_k_ranked_table_top.sv
test/top_k_ranked_table_top_tb.sv
